@@ src/msw_pkg.sv @@
// shared types, codes and helpers for the multi-slot watchdog
`timescale 1ns / 1ps

package msw_pkg;

   // deactivate must present this code or the trip latch is set
   localparam logic [31:0] DISABLE_CODE = 32'h2840_1852;
   localparam logic [31:0] HANDLE_TOP   = 32'h8000_0000;
   localparam logic [7:0]  ID_MASK      = 8'hff;

   // operation codes carried by each request
   typedef logic [2:0] mode_type;
   localparam mode_type MODE_REGISTER   = 3'd0;
   localparam mode_type MODE_ACTIVATE   = 3'd1;
   localparam mode_type MODE_SERVICE    = 3'd2;
   localparam mode_type MODE_DEACTIVATE = 3'd3;
   localparam mode_type MODE_TICK       = 3'd4;
   localparam mode_type MODE_CHECK      = 3'd5;

   // response status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK         = 2'd0;
   localparam status_type STATUS_NO_FREE    = 2'd1;
   localparam status_type STATUS_BAD_HANDLE = 2'd2;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ADD,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       capture;
      logic       reg_slot;
      logic       update_dl;
      logic       set_enable;
      logic       deactivate;
      logic       tick;
      logic       scan_start;
      logic       scan_step;
      logic       set_status;
      status_type status;
      logic       load_rsp;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      mode_type mode;
      logic     handle_ok;
      logic     slots_full;
      logic     scan_last;
      logic     rsp_busy;
   } sts_type;

   // handle for a slot id: top byte 0x80 | id, next ~id, low byte id
   function automatic logic [31:0] encode_handle(input logic [7:0] id);
      logic [7:0] top;
      top = HANDLE_TOP[31:24] | id;
      return {top, (~id) & ID_MASK, 8'h00, id};
   endfunction

endpackage

@@ src/msw_if.sv @@
// request and response channel interfaces of the multi-slot watchdog
`timescale 1ns / 1ps

interface msw_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [31:0] handle;
   logic [31:0] lifetime;
   logic [31:0] disable_code;

   modport source (output valid, mode, handle, lifetime, disable_code, input ready);
   modport sink   (input valid, mode, handle, lifetime, disable_code, output ready);
endinterface

interface msw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] new_handle;
   logic        tripped;
   logic        kick;

   modport source (output valid, status, new_handle, tripped, kick, input ready);
   modport sink   (input valid, status, new_handle, tripped, kick, output ready);
endinterface

@@ src/multi_slot_watchdog_top.sv @@
// Multi-slot watchdog top level.
// Requests arrive on req_chan (valid/ready) carrying mode, handle, lifetime
// and disable_code; each request yields exactly one response on rsp_chan
// with status, new_handle, tripped and kick. A transfer happens when valid
// and ready are both high at a rising clock edge.
// Requests are handled one at a time: a request passes through the
// idle, execute and done steps from transfer to the next ready; activate
// and service add an add step for the lifetime read and deadline add;
// check adds scan steps and a drain step, as the deadline store is
// scanned one slot per cycle through its read port. The done step loads
// the response into the output register.
// The output register lets the next request be taken while a response
// still waits; when the receiver stalls and the register is still full,
// the next request holds in its done step until the response is taken.
// Synchronous reset clears the enable bits, free-slot pointer, time,
// trip latch and the channel valid; lifetime and deadline stores are not
// cleared and need no clearing pass.
`timescale 1ns / 1ps

module multi_slot_watchdog_top
   import msw_pkg::*;
#(
   parameter int SLOT_COUNT = 16
)
(
   input logic      clock,
   input logic      reset,
   msw_req_if.sink  req_chan,
   msw_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   // sequencing
   msw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot stores and response register
   msw_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_chan.mode),
      .req_handle       (req_chan.handle),
      .req_lifetime     (req_chan.lifetime),
      .req_disable_code (req_chan.disable_code),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_new_handle   (rsp_chan.new_handle),
      .rsp_tripped      (rsp_chan.tripped),
      .rsp_kick         (rsp_chan.kick)
   );

endmodule

@@ src/msw_ctrl.sv @@
// controller state machine: sequences one request through the datapath
`timescale 1ns / 1ps

module msw_ctrl
   import msw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.status = STATUS_OK;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.set_status = 1'b1;
            state_in       = ST_DONE;
            case (sts.mode)
               MODE_REGISTER: begin
                  cmd.status   = sts.slots_full ? STATUS_NO_FREE : STATUS_OK;
                  cmd.reg_slot = !sts.slots_full;
               end
               MODE_ACTIVATE, MODE_SERVICE: begin
                  cmd.status = sts.handle_ok ? STATUS_OK : STATUS_BAD_HANDLE;
                  if (sts.handle_ok) begin
                     state_in = ST_ADD;
                  end
               end
               MODE_DEACTIVATE: begin
                  cmd.status     = sts.handle_ok ? STATUS_OK : STATUS_BAD_HANDLE;
                  cmd.deactivate = sts.handle_ok;
               end
               MODE_TICK: begin
                  cmd.tick = 1'b1;
               end
               MODE_CHECK: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
               default: begin
                  cmd.status = STATUS_OK;
               end
            endcase
         end
         ST_ADD: begin
            cmd.update_dl  = 1'b1;
            cmd.set_enable = (sts.mode == MODE_ACTIVATE);
            state_in       = ST_DONE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a transfer is only taken from the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not move to execute");

   // the scan ends with a drain step for the last comparison
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && sts.scan_last) |=> (state_ff == ST_DRAIN))
      else $error("scan did not drain after the last slot");

endmodule

@@ src/msw_datapath.sv @@
// datapath: slot stores, time counter, trip latch and response register
`timescale 1ns / 1ps

module msw_datapath
   import msw_pkg::*;
#(
   parameter int SLOT_COUNT = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_handle,
   input  logic [31:0] req_lifetime,
   input  logic [31:0] req_disable_code,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_new_handle,
   output logic        rsp_tripped,
   output logic        rsp_kick
);

   localparam int ID_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   // captured request
   mode_type    mode_ff;
   logic [31:0] handle_ff;
   logic [31:0] lifetime_ff;
   logic [31:0] code_ff;

   // slot state
   logic [SLOT_COUNT-1:0] enabled_ff;
   logic [31:0]           life_mem [SLOT_COUNT];
   logic [63:0]           dl_mem   [SLOT_COUNT];
   logic [31:0]           life_rd_ff;
   logic [63:0]           dl_rd_ff;
   logic [CNT_W-1:0]      next_free_ff;
   logic [63:0]           now_ff;
   logic                  trip_ff;

   // scan pipeline
   logic [CNT_W-1:0] scan_cnt_ff;
   logic             cmp_valid_ff;
   logic             cmp_en_ff;

   // response register
   logic        rsp_valid_ff;
   status_type  status_ff;
   logic [31:0] new_handle_ff;
   status_type  rsp_status_ff;
   logic [31:0] rsp_handle_ff;
   logic        rsp_tripped_ff;
   logic        rsp_kick_ff;

   logic [7:0]      hid;
   logic            handle_ok;
   logic [ID_W-1:0] slot_idx;
   logic [ID_W-1:0] reg_idx;
   logic [ID_W-1:0] scan_idx;
   logic            slots_full;
   logic [63:0]     deadline_in;
   logic            late;

   function automatic logic [7:0] req_handle_id(input logic [31:0] h);
      return h[7:0] & ID_MASK;
   endfunction

   // handle decode
   assign hid       = req_handle_id(handle_ff);
   assign handle_ok = (handle_ff == encode_handle(hid)) && ({24'd0, hid} < 32'(SLOT_COUNT));
   assign slot_idx  = handle_ff[ID_W-1:0];
   assign reg_idx   = next_free_ff[ID_W-1:0];
   assign scan_idx  = scan_cnt_ff[ID_W-1:0];
   assign slots_full = (next_free_ff >= CNT_W'(SLOT_COUNT));

   // status towards the controller
   assign sts.mode       = mode_ff;
   assign sts.handle_ok  = handle_ok;
   assign sts.slots_full = slots_full;
   assign sts.scan_last  = (scan_cnt_ff == CNT_W'(SLOT_COUNT - 1));
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         handle_ff   <= req_handle;
         lifetime_ff <= req_lifetime;
         code_ff     <= req_disable_code;
      end
   end

   // lifetime store, read at the handle's slot
   always_ff @(posedge clock) begin
      if (cmd.reg_slot) begin
         life_mem[reg_idx] <= lifetime_ff;
      end
      life_rd_ff <= life_mem[slot_idx];
   end

   // deadline store, read at the scan position
   assign deadline_in = now_ff + {32'd0, life_rd_ff};

   always_ff @(posedge clock) begin
      if (cmd.update_dl) begin
         dl_mem[slot_idx] <= deadline_in;
      end
      dl_rd_ff <= dl_mem[scan_idx];
   end

   // enable bits, free pointer, time and trip latch
   assign late = cmp_valid_ff && cmp_en_ff && (dl_rd_ff < now_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= '0;
         next_free_ff <= '0;
         now_ff       <= '0;
         trip_ff      <= 1'b0;
      end else begin
         if (cmd.reg_slot) begin
            enabled_ff[reg_idx] <= 1'b0;
            next_free_ff        <= next_free_ff + CNT_W'(1);
         end
         if (cmd.update_dl && cmd.set_enable) begin
            enabled_ff[slot_idx] <= 1'b1;
         end
         if (cmd.deactivate) begin
            enabled_ff[slot_idx] <= 1'b0;
            if (code_ff != DISABLE_CODE) begin
               trip_ff <= 1'b1;
            end
         end
         if (cmd.tick) begin
            now_ff <= now_ff + 64'd1;
         end
         if (late) begin
            trip_ff <= 1'b1;
         end
      end
   end

   // scan counter and compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff  <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_step;
         if (cmd.scan_start) begin
            scan_cnt_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_cnt_ff <= scan_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_en_ff <= enabled_ff[scan_idx];
   end

   // result of the execute step
   always_ff @(posedge clock) begin
      if (cmd.set_status) begin
         status_ff     <= cmd.status;
         new_handle_ff <= cmd.reg_slot ? encode_handle(8'(next_free_ff)) : 32'd0;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff  <= status_ff;
         rsp_handle_ff  <= new_handle_ff;
         rsp_tripped_ff <= trip_ff;
         rsp_kick_ff    <= (mode_ff == MODE_CHECK) && !trip_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_new_handle = rsp_handle_ff;
   assign rsp_tripped    = rsp_tripped_ff;
   assign rsp_kick       = rsp_kick_ff;

   // the trip latch only clears on reset
   assert property (@(posedge clock) disable iff (reset) trip_ff |=> trip_ff)
      else $error("trip latch cleared without reset");

   // the free pointer never runs past the slot count
   assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= CNT_W'(SLOT_COUNT))
      else $error("free slot pointer overran");

   // a kick is never reported together with a trip
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_kick_ff && rsp_tripped_ff))
      else $error("kick given while tripped");

endmodule
